[sv/kha_pkg.sv]
// ----------------------------------------------------------------------------
// kha_pkg: shared definitions for the K-of-N hysteresis alarm
// Widths, register map codes and the configuration and result structures
// used by the register file, the evaluation core and the top level.
// ----------------------------------------------------------------------------
package kha_pkg;

   // Largest detection window, in items.
   localparam int MAX_WINDOW = 32;

   // Width of the window length, the thresholds and the counts.
   localparam int WIN_W = 6;

   // Width of the wrapping onset counter.
   localparam int ONSET_W = 32;

   // Configuration port geometry.
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;

   // Register byte addresses.
   localparam logic [ADDR_W-1:0] ADDR_WINDOW_LEN    = 4'h0;
   localparam logic [ADDR_W-1:0] ADDR_ON_THRESHOLD  = 4'h4;
   localparam logic [ADDR_W-1:0] ADDR_OFF_THRESHOLD = 4'h8;

   // Register reset values.
   localparam logic [WIN_W-1:0] RESET_WINDOW_LEN    = 6'd8;
   localparam logic [WIN_W-1:0] RESET_ON_THRESHOLD  = 6'd5;
   localparam logic [WIN_W-1:0] RESET_OFF_THRESHOLD = 6'd3;

   // Stream widths.
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 48;

   // Configuration seen by the core.
   typedef struct packed {
      logic [WIN_W-1:0] window_len;
      logic [WIN_W-1:0] on_threshold;
      logic [WIN_W-1:0] off_threshold;
   } cfg_type;

   // One result; the last member sits in the lowest bits.
   typedef struct packed {
      logic [ONSET_W-1:0] onset_total;
      logic [WIN_W-1:0]   samples_seen;
      logic [WIN_W-1:0]   hit_count;
      logic               changed;
      logic               alarm_on;
   } result_type;

   localparam int RESULT_W = $bits(result_type);
   localparam int RSP_PAD_W = RSP_TDATA_W - RESULT_W;

endpackage

[sv/kha_csr.sv]
// ----------------------------------------------------------------------------
// kha_csr: configuration registers
// Holds the window length and the two thresholds behind an APB-style port.
// ----------------------------------------------------------------------------
module kha_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [kha_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [kha_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [kha_pkg::DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready,
   output kha_pkg::cfg_type            cfg
);

   logic [kha_pkg::WIN_W-1:0] window_len_ff;
   logic [kha_pkg::WIN_W-1:0] on_threshold_ff;
   logic [kha_pkg::WIN_W-1:0] off_threshold_ff;
   logic                      write_en;
   logic [kha_pkg::WIN_W-1:0] wdata;

   // The port never inserts wait states.
   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign wdata      = csr_pwdata[kha_pkg::WIN_W-1:0];

   // Register writes; only the low bits of the data are kept.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff    <= kha_pkg::RESET_WINDOW_LEN;
         on_threshold_ff  <= kha_pkg::RESET_ON_THRESHOLD;
         off_threshold_ff <= kha_pkg::RESET_OFF_THRESHOLD;
      end else if (write_en) begin
         unique case (csr_paddr)
            kha_pkg::ADDR_WINDOW_LEN:    window_len_ff    <= wdata;
            kha_pkg::ADDR_ON_THRESHOLD:  on_threshold_ff  <= wdata;
            kha_pkg::ADDR_OFF_THRESHOLD: off_threshold_ff <= wdata;
            default: ;
         endcase
      end
   end

   // Read mux; unmapped addresses read as zero.
   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr)
         kha_pkg::ADDR_WINDOW_LEN:
            csr_prdata = kha_pkg::DATA_W'(window_len_ff);
         kha_pkg::ADDR_ON_THRESHOLD:
            csr_prdata = kha_pkg::DATA_W'(on_threshold_ff);
         kha_pkg::ADDR_OFF_THRESHOLD:
            csr_prdata = kha_pkg::DATA_W'(off_threshold_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   assign cfg.window_len    = window_len_ff;
   assign cfg.on_threshold  = on_threshold_ff;
   assign cfg.off_threshold = off_threshold_ff;

endmodule

[sv/kha_core.sv]
// ----------------------------------------------------------------------------
// kha_core: detection history and alarm evaluation
// Keeps the history, fill count, alarm state and onset counter, and works
// out the result of the registered input item in a single pass.
// ----------------------------------------------------------------------------
module kha_core (
   input  logic                 clock,
   input  logic                 reset,
   input  kha_pkg::cfg_type     cfg,
   input  logic                 fire,
   input  logic                 detected,
   output kha_pkg::result_type  result
);

   logic [kha_pkg::MAX_WINDOW-1:0] history_ff;
   logic [kha_pkg::MAX_WINDOW-1:0] history_in;
   logic [kha_pkg::WIN_W-1:0]      fill_ff;
   logic [kha_pkg::WIN_W-1:0]      fill_in;
   logic                           alarm_ff;
   logic                           alarm_in;
   logic [kha_pkg::ONSET_W-1:0]    onset_ff;
   logic [kha_pkg::ONSET_W-1:0]    onset_in;
   logic [kha_pkg::WIN_W-1:0]      win_eff;
   logic [kha_pkg::MAX_WINDOW-1:0] win_mask;
   logic [kha_pkg::WIN_W-1:0]      hits;

   // Population count of 32 bits as a five-level adder tree.
   function automatic logic [5:0] popcount32(input logic [31:0] v);
      logic [1:0] l1 [16];
      logic [2:0] l2 [8];
      logic [3:0] l3 [4];
      logic [4:0] l4 [2];
      for (int i = 0; i < 16; i++) l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
      for (int i = 0; i < 8; i++)  l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
      for (int i = 0; i < 4; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
      for (int i = 0; i < 2; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
      return {1'b0, l4[0]} + {1'b0, l4[1]};
   endfunction

   // The window is clamped to the history length.
   assign win_eff = (cfg.window_len > kha_pkg::WIN_W'(kha_pkg::MAX_WINDOW))
                  ? kha_pkg::WIN_W'(kha_pkg::MAX_WINDOW) : cfg.window_len;

   // Thermometer mask over the newest win_eff bits.
   always_comb begin
      for (int i = 0; i < kha_pkg::MAX_WINDOW; i++) begin
         win_mask[i] = (kha_pkg::WIN_W'(i) < win_eff);
      end
   end

   // Shift in the new bit, count hits and apply the hysteresis.
   always_comb begin
      history_in = {history_ff[kha_pkg::MAX_WINDOW-2:0], detected};
      fill_in    = (fill_ff < win_eff) ? fill_ff + 1'b1 : fill_ff;
      hits       = popcount32(history_in & win_mask);
      priority if (!alarm_ff && (hits >= cfg.on_threshold)) begin
         alarm_in = 1'b1;
         onset_in = onset_ff + 1'b1;
      end else if (alarm_ff && (hits < cfg.off_threshold)) begin
         alarm_in = 1'b0;
         onset_in = onset_ff;
      end else begin
         alarm_in = alarm_ff;
         onset_in = onset_ff;
      end
   end

   assign result.alarm_on     = alarm_in;
   assign result.changed      = alarm_in ^ alarm_ff;
   assign result.hit_count    = hits;
   assign result.samples_seen = fill_in;
   assign result.onset_total  = onset_in;

   // State advances once per transaction handed to the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff <= '0;
         fill_ff    <= '0;
         alarm_ff   <= 1'b0;
         onset_ff   <= '0;
      end else if (fire) begin
         history_ff <= history_in;
         fill_ff    <= fill_in;
         alarm_ff   <= alarm_in;
         onset_ff   <= onset_in;
      end
   end

   // The onset counter moves only with an off-to-on change.
   a_onset_step: assert property (@(posedge clock) disable iff (reset)
      fire |=> onset_ff == $past(onset_ff) + kha_pkg::ONSET_W'($past(result.changed
         && result.alarm_on)))
      else $error("onset counter out of step with alarm changes");

   // The stored alarm follows the reported one.
   a_alarm_follows: assert property (@(posedge clock) disable iff (reset)
      fire |=> alarm_ff == $past(result.alarm_on))
      else $error("alarm state differs from reported result");

   // Without a transaction the state holds.
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(history_ff) && $stable(fill_ff) && $stable(onset_ff))
      else $error("state changed without a transaction");

endmodule

[sv/k_of_n_hysteresis_alarm.sv]
// ----------------------------------------------------------------------------
// k_of_n_hysteresis_alarm: K-of-N detector with hysteresis
// Counts detections over a sliding window and raises or clears an alarm
// with separate on and off thresholds.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle unless stalled and returns
// one result per transaction, held first in the input register and then in
// the result register. The hit count, alarm decision and state update are
// worked out combinationally between these two registers, so back-pressure on
// the result side stalls the input side only once both registers are full.
// Thresholds and the window length are to be written by the user through the
// register port while no transaction is in flight; the block does not enforce it.
module k_of_n_hysteresis_alarm (
   input  logic                             clock,
   input  logic                             reset,
   // Request stream; tdata: [0] detected, [7:1] zero.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [kha_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // Result stream; tdata: [0] alarm_on, [1] changed, [7:2] hit_count,
   // [13:8] samples_seen, [45:14] onset_total, [47:46] zero.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [kha_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // Register port.
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [kha_pkg::ADDR_W-1:0]       csr_paddr,
   input  logic [kha_pkg::DATA_W-1:0]       csr_pwdata,
   output logic [kha_pkg::DATA_W-1:0]       csr_prdata,
   output logic                             csr_pready
);

   kha_pkg::cfg_type    cfg;
   kha_pkg::result_type result;
   kha_pkg::result_type rsp_data_ff;
   logic                in_valid_ff;
   logic                in_detected_ff;
   logic                rsp_valid_ff;
   logic                advance;
   logic                req_accept;

   kha_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   kha_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .fire     (advance),
      .detected (in_detected_ff),
      .result   (result)
   );

   // A transaction moves on when the result register is free or draining.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_detected_ff <= req_tdata[0];
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{kha_pkg::RSP_PAD_W{1'b0}}, rsp_data_ff};

   // Back-pressure reaches the input only when both registers are occupied.
   a_ready_when_room: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && rsp_valid_ff && !rsp_tready)
      else $error("input stalled with room in the pipeline");

   // A stalled result is not overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !advance)
      else $error("result register overwritten while stalled");

endmodule
